/* design/twl_pkg.sv */
// twl_pkg: payload types and fixed codes for the text window line writer
// no dependencies; the interface, result register and core refer to it by scoped names
package twl_pkg;

    // one command transfer
    typedef struct packed {
        logic       func;
        logic [1:0] window;
        logic [7:0] char_code;
    } cmd_t;

    // one result transfer
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] out_window;
        logic [4:0] row;
        logic [4:0] column;
        logic [7:0] cell_char;
        logic       scroll_first;
        logic       last;
    } res_t;

    // command functions
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_CELL    = 2'd0;
    localparam logic [1:0] KIND_CLEAR   = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // tab stops every four columns
    localparam int TAB_STOP = 4;

endpackage

/* design/twl_if.sv */
// twl_if: valid/ready channels for commands and results
// depends on twl_pkg for the payload types
interface twl_cmd_if;
    logic            valid;
    logic            ready;
    twl_pkg::cmd_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface twl_res_if;
    logic            valid;
    logic            ready;
    twl_pkg::res_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/twl_ram.sv */
// twl_ram: generic single write port, single read port ram with registered read
// no dependencies
module twl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/twl_cursor_store.sv */
// twl_cursor_store: per-window cursor row and pending count in a ram,
// with a valid bit per window so that an unwritten entry reads as zero
// depends on twl_ram
module twl_cursor_store #(
    parameter int WINDOWS = 4,
    parameter int ROW_W   = 5,
    parameter int CNT_W   = 6,
    parameter int IDX_W   = (WINDOWS > 1) ? $clog2(WINDOWS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [ROW_W-1:0] rd_row,
    output logic [CNT_W-1:0] rd_cnt,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [ROW_W-1:0] wr_row,
    input  logic [CNT_W-1:0] wr_cnt
);

    localparam int ENTRY_W = ROW_W + CNT_W;

    logic [WINDOWS-1:0]  valid_reg;
    logic                rd_valid_reg;
    logic [ENTRY_W-1:0]  ram_rdata;

    twl_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (WINDOWS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({wr_row, wr_cnt}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // valid bits, cleared at reset, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as the reset value
    assign rd_row = rd_valid_reg ? ram_rdata[ENTRY_W-1:CNT_W] : '0;
    assign rd_cnt = rd_valid_reg ? ram_rdata[CNT_W-1:0] : '0;

endmodule

/* design/twl_result_reg.sv */
// twl_result_reg: output register that holds one result until its transfer
// depends on twl_pkg and twl_if
module twl_result_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  twl_pkg::res_t  item,
    output logic           free,
    twl_res_if.source      res
);

    logic          valid_reg;
    twl_pkg::res_t data_reg;

    // register is free when empty or emptying this cycle
    assign free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= item;
        end
    end

    assign res.valid = valid_reg;
    assign res.data  = data_reg;

endmodule

/* design/text_window_line_writer_core.sv */
// Text window line writer: one command at a time. A printable character
// goes through a state ram lookup, then an update, before the next command
// can be taken; a tab writes its padding spaces one per cycle (up to 4),
// since the line buffer ram has one write port. A flush sends each cell
// through the line buffer's registered read port into the single output
// register, waiting while the output stalls. Clear and empty newline
// results are loaded from their own state. Cursor state lives in a small
// ram with a valid bit per window, so no clearing pass is needed after reset.
// depends on twl_pkg, twl_if, twl_ram, twl_cursor_store, twl_result_reg
module text_window_line_writer_core #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 24,
    parameter int WINDOWS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    twl_cmd_if.sink    cmd,
    twl_res_if.source  res
);

    localparam int ROW_W     = $clog2(ROWS);
    localparam int CNT_W     = $clog2(COLUMNS + 1);
    localparam int IDX_W     = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int BUF_DEPTH = WINDOWS * COLUMNS;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(COLUMNS);
    localparam logic [CNT_W-1:0] TAB_MASK = CNT_W'(twl_pkg::TAB_STOP - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    // sequencer codes
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOOK    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_TAB     = 3'd3;
    localparam logic [2:0] S_SINGLE  = 3'd4;
    localparam logic [2:0] S_FL_RD   = 3'd5;
    localparam logic [2:0] S_FL_WAIT = 3'd6;

    logic [2:0]       state_reg,  state_next;
    logic             func_reg,   func_next;
    logic [1:0]       win_reg,    win_next;
    logic [7:0]       ch_reg,     ch_next;
    logic [ROW_W-1:0] row_reg,    row_next;
    logic [CNT_W-1:0] n_reg,      n_next;
    logic [CNT_W-1:0] k_reg,      k_next;
    logic             scroll_reg, scroll_next;
    logic [1:0]       kind_reg,   kind_next;

    logic             cs_rd_en;
    logic [IDX_W-1:0] cs_rd_addr;
    logic [ROW_W-1:0] cs_rd_row;
    logic [CNT_W-1:0] cs_rd_cnt;
    logic             cs_wr_en;
    logic [IDX_W-1:0] cs_wr_addr;
    logic [ROW_W-1:0] cs_wr_row;
    logic [CNT_W-1:0] cs_wr_cnt;

    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr;
    logic [7:0]        buf_wdata;
    logic              buf_re;
    logic [BUF_AW-1:0] buf_raddr;
    logic [7:0]        buf_rdata;

    logic              res_load;
    logic              res_free;
    twl_pkg::res_t     res_item;

    logic [CNT_W-1:0]  n_inc;
    logic [CNT_W-1:0]  k_inc;
    logic [ROW_W-1:0]  row_adv;
    logic              at_last_row;
    logic              line_full;
    logic              cell_last;

    // buffer address of a cell in a window's line
    function automatic logic [BUF_AW-1:0] buf_addr(input logic [1:0] win,
                                                   input logic [CNT_W-1:0] idx);
        buf_addr = BUF_AW'(int'(win) * COLUMNS + int'(idx));
    endfunction

    twl_cursor_store #(
        .WINDOWS (WINDOWS),
        .ROW_W   (ROW_W),
        .CNT_W   (CNT_W),
        .IDX_W   (IDX_W)
    ) u_cursor (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cs_rd_en),
        .rd_addr (cs_rd_addr),
        .rd_row  (cs_rd_row),
        .rd_cnt  (cs_rd_cnt),
        .wr_en   (cs_wr_en),
        .wr_addr (cs_wr_addr),
        .wr_row  (cs_wr_row),
        .wr_cnt  (cs_wr_cnt)
    );

    twl_ram #(
        .WIDTH  (8),
        .DEPTH  (BUF_DEPTH),
        .ADDR_W (BUF_AW)
    ) u_line_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    twl_result_reg u_result (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .item  (res_item),
        .free  (res_free),
        .res   (res)
    );

    // commands are taken only between items
    assign cmd.ready = (state_reg == S_IDLE);

    // derived values of the current item
    assign n_inc       = n_reg + CNT_W'(1);
    assign k_inc       = k_reg + CNT_W'(1);
    assign at_last_row = (row_reg == ROW_LAST);
    assign row_adv     = (row_reg < ROW_LAST) ? row_reg + ROW_W'(1) : row_reg;
    assign line_full   = (n_inc == CNT_FULL);
    assign cell_last   = (k_inc == n_reg);

    assign cs_rd_addr = IDX_W'(cmd.data.window);
    assign cs_wr_addr = IDX_W'(win_reg);
    assign buf_waddr  = buf_addr(win_reg, n_reg);
    assign buf_raddr  = buf_addr(win_reg, k_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        win_next    = win_reg;
        ch_next     = ch_reg;
        row_next    = row_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        scroll_next = scroll_reg;
        kind_next   = kind_reg;
        cs_rd_en    = 1'b0;
        cs_wr_en    = 1'b0;
        cs_wr_row   = row_reg;
        cs_wr_cnt   = '0;
        buf_we      = 1'b0;
        buf_wdata   = ch_reg;
        buf_re      = 1'b0;
        res_load    = 1'b0;
        res_item    = '0;

        case (state_reg)
            S_IDLE:
            begin
                // drop commands for windows that do not exist
                if (cmd.valid && (int'(cmd.data.window) < WINDOWS))
                begin
                    func_next  = cmd.data.func;
                    win_next   = cmd.data.window;
                    ch_next    = cmd.data.char_code;
                    cs_rd_en   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                row_next   = cs_rd_row;
                n_next     = cs_rd_cnt;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (func_reg == twl_pkg::FUNC_CLEAR)
                begin
                    cs_wr_en    = 1'b1;
                    cs_wr_row   = '0;
                    row_next    = '0;
                    scroll_next = 1'b0;
                    kind_next   = twl_pkg::KIND_CLEAR;
                    state_next  = S_SINGLE;
                end
                else if (ch_reg == twl_pkg::CH_TAB)
                begin
                    state_next = S_TAB;
                end
                else if (ch_reg == twl_pkg::CH_NL)
                begin
                    cs_wr_en    = 1'b1;
                    cs_wr_row   = row_adv;
                    scroll_next = at_last_row;
                    k_next      = '0;
                    if (n_reg == '0)
                    begin
                        kind_next  = twl_pkg::KIND_ADVANCE;
                        state_next = S_SINGLE;
                    end
                    else
                    begin
                        state_next = S_FL_RD;
                    end
                end
                else
                begin
                    // literal character into the buffer
                    buf_we   = 1'b1;
                    cs_wr_en = 1'b1;
                    if (line_full)
                    begin
                        cs_wr_row   = row_adv;
                        n_next      = n_inc;
                        k_next      = '0;
                        scroll_next = at_last_row;
                        state_next  = S_FL_RD;
                    end
                    else
                    begin
                        cs_wr_cnt  = n_inc;
                        state_next = S_IDLE;
                    end
                end
            end
            S_TAB:
            begin
                // one padding space per cycle
                buf_we    = 1'b1;
                buf_wdata = twl_pkg::CH_SPACE;
                n_next    = n_inc;
                if (line_full)
                begin
                    cs_wr_en    = 1'b1;
                    cs_wr_row   = row_adv;
                    k_next      = '0;
                    scroll_next = at_last_row;
                    state_next  = S_FL_RD;
                end
                else if ((n_inc & TAB_MASK) == '0)
                begin
                    cs_wr_en   = 1'b1;
                    cs_wr_cnt  = n_inc;
                    state_next = S_IDLE;
                end
            end
            S_SINGLE:
            begin
                // clear or empty line advance result
                if (res_free)
                begin
                    res_load              = 1'b1;
                    res_item.kind         = kind_reg;
                    res_item.out_window   = win_reg;
                    res_item.row          = 5'(row_reg);
                    res_item.scroll_first = scroll_reg;
                    res_item.last         = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            S_FL_RD:
            begin
                // fetch the next cell once the output register will be empty
                if (res_free)
                begin
                    buf_re     = 1'b1;
                    state_next = S_FL_WAIT;
                end
            end
            S_FL_WAIT:
            begin
                res_load              = 1'b1;
                res_item.kind         = twl_pkg::KIND_CELL;
                res_item.out_window   = win_reg;
                res_item.row          = 5'(row_reg);
                res_item.column       = 5'(k_reg);
                res_item.cell_char    = buf_rdata;
                res_item.scroll_first = scroll_reg && (k_reg == '0);
                res_item.last         = cell_last;
                if (cell_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = S_FL_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        win_reg    <= win_next;
        ch_reg     <= ch_next;
        row_reg    <= row_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        scroll_reg <= scroll_next;
        kind_reg   <= kind_next;
    end

`ifndef NO_ASSERTIONS
    // a cell read is issued only when the output register will be empty
    a_cell_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FL_WAIT |-> !res.valid)
        else $error("cell read landed on an occupied output register");

    // flush index stays inside the pending line
    a_flush_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FL_RD || state_reg == S_FL_WAIT) |-> (k_reg < n_reg))
        else $error("flush index beyond pending count");

    // tab padding never runs past the line
    a_tab_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAB |-> (n_reg < CNT_FULL))
        else $error("tab padding past end of line");

    // stored cursor row stays on screen
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |-> (row_reg <= ROW_LAST))
        else $error("cursor row beyond last row");

    // the final cell of a flush returns the sequencer to idle
    a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FL_WAIT && cell_last) |=> (state_reg == S_IDLE))
        else $error("flush did not end after its last cell");
`endif

endmodule

/* sim/text_window_line_writer_core_tb.sv */
// text_window_line_writer_core_tb: self-checking bench for the text window line writer
// depends on twl_pkg, twl_if and the text_window_line_writer_core rtl
module text_window_line_writer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = 32;
    localparam int ROWS         = 24;
    localparam int WINDOWS      = 4;
    localparam int TOTAL_ITEMS  = 400;
    localparam int CALM_FROM    = 150;
    localparam int CALM_TO      = 260;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_LIMIT = 10;

    logic clk;
    logic rst_n;

    twl_cmd_if cmd_ch ();
    twl_res_if res_ch ();

    text_window_line_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS),
        .WINDOWS(WINDOWS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .res  (res_ch)
    );

    // commands waiting to be driven and results waiting to be seen
    twl_pkg::cmd_t char_queue[$];
    twl_pkg::res_t expected_cells[$];

    // shadow of each window's cursor and line buffer
    logic [4:0] cur_row[WINDOWS];
    int         fill[WINDOWS];
    logic [7:0] line_buf[WINDOWS][COLUMNS];

    int accepted_count;
    int queued_count;
    int error_count;

    // idle with a chance of about one in five, never during the calm stretch
    function automatic bit take_break();
        return (accepted_count < CALM_FROM || accepted_count >= CALM_TO)
            && ($urandom_range(99) < 21);
    endfunction

    // work out the results one accepted command causes
    function automatic void predict_line_writes(twl_pkg::cmd_t c);
        int            w;
        int            n;
        int            k;
        logic [4:0]    r;
        bit            scroll;
        twl_pkg::res_t e;
        w = c.window;
        if (w >= WINDOWS)
            return;
        e = '0;
        e.out_window = c.window;
        if (c.func == twl_pkg::FUNC_CLEAR)
        begin
            cur_row[w] = '0;
            fill[w]    = 0;
            e.kind     = twl_pkg::KIND_CLEAR;
            e.last     = 1'b1;
            expected_cells.push_back(e);
            return;
        end
        n = (fill[w] >= COLUMNS) ? 0 : fill[w];
        r = cur_row[w];
        // tab pads with spaces up to the next stop, newline is never buffered
        if (c.char_code == twl_pkg::CH_TAB)
        begin
            do
            begin
                line_buf[w][n] = twl_pkg::CH_SPACE;
                n++;
            end while (n < COLUMNS && (n % twl_pkg::TAB_STOP) != 0);
        end
        else if (c.char_code != twl_pkg::CH_NL)
        begin
            line_buf[w][n] = c.char_code;
            n++;
        end
        if (c.char_code != twl_pkg::CH_NL && n < COLUMNS)
        begin
            fill[w] = n;
            return;
        end
        // flush: either one advance or a run of cell writes on the current row
        scroll = (r == ROWS - 1);
        e.row  = r;
        if (n == 0)
        begin
            e.kind         = twl_pkg::KIND_ADVANCE;
            e.scroll_first = scroll;
            e.last         = 1'b1;
            expected_cells.push_back(e);
        end
        else
        begin
            for (k = 0; k < n; k++)
            begin
                e.kind         = twl_pkg::KIND_CELL;
                e.column       = k[4:0];
                e.cell_char    = line_buf[w][k];
                e.scroll_first = (k == 0) && scroll;
                e.last         = (k + 1 == n);
                expected_cells.push_back(e);
            end
        end
        if (r < ROWS - 1)
            r++;
        cur_row[w] = r;
        fill[w]    = 0;
    endfunction

    function automatic void queue_cmd(logic func, int w, int ch);
        twl_pkg::cmd_t c;
        c.func      = func;
        c.window    = w[1:0];
        c.char_code = ch[7:0];
        char_queue.push_back(c);
        queued_count++;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // command driver: predict on each transfer, then load the next command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_line_writes(cmd_ch.data);
                accepted_count <= accepted_count + 1;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (char_queue.size() > 0 && !take_break())
                begin
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.data  <= char_queue.pop_front();
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor: compare each transfer with the oldest expected cell
    always @(posedge clk)
    begin : result_monitor
        twl_pkg::res_t want;
        twl_pkg::res_t got;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.data;
                if (expected_cells.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t unexpected result: kind %0d win %0d row %0d col %0d",
                                 $realtime, got.kind, got.out_window, got.row, got.column);
                    error_count++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (got.kind !== want.kind || got.out_window !== want.out_window
                        || got.row !== want.row || got.column !== want.column
                        || got.cell_char !== want.cell_char
                        || got.scroll_first !== want.scroll_first
                        || got.last !== want.last)
                    begin
                        if (error_count < REPORT_LIMIT)
                        begin
                            $display("%0t mismatch, expected: kind %0d win %0d row %0d",
                                     $realtime, want.kind, want.out_window, want.row);
                            $display("    col %0d char %0d scroll %0b last %0b",
                                     want.column, want.cell_char, want.scroll_first,
                                     want.last);
                            $display("  actual: kind %0d win %0d row %0d col %0d",
                                     got.kind, got.out_window, got.row, got.column);
                            $display("    char %0d scroll %0b last %0b",
                                     got.cell_char, got.scroll_first, got.last);
                        end
                        error_count++;
                    end
                end
            end
            res_ch.ready <= !take_break();
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int pick;
        int w;
        int len;
        int lp;
        int i;
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.data    = '0;
        res_ch.ready   = 1'b0;
        accepted_count = 0;
        queued_count   = 0;
        error_count    = 0;
        for (i = 0; i < WINDOWS; i++)
        begin
            cur_row[i] = '0;
            fill[i]    = 0;
        end

        // clear every window, char field at its extremes and in alternating bit patterns
        queue_cmd(twl_pkg::FUNC_CLEAR, 0, 8'h00);
        queue_cmd(twl_pkg::FUNC_CLEAR, 3, 8'hff);
        queue_cmd(twl_pkg::FUNC_CLEAR, 1, 8'haa);
        queue_cmd(twl_pkg::FUNC_CLEAR, 2, 8'h55);
        // smallest and largest codes flushed by a newline, then an empty newline
        queue_cmd(twl_pkg::FUNC_WRITE, 0, 8'h00);
        queue_cmd(twl_pkg::FUNC_WRITE, 0, 8'hff);
        queue_cmd(twl_pkg::FUNC_WRITE, 0, twl_pkg::CH_NL);
        queue_cmd(twl_pkg::FUNC_WRITE, 0, twl_pkg::CH_NL);
        // tabs around a literal
        queue_cmd(twl_pkg::FUNC_WRITE, 3, twl_pkg::CH_TAB);
        queue_cmd(twl_pkg::FUNC_WRITE, 3, 8'h41);
        queue_cmd(twl_pkg::FUNC_WRITE, 3, twl_pkg::CH_TAB);
        queue_cmd(twl_pkg::FUNC_WRITE, 3, twl_pkg::CH_NL);
        // tabs alone fill a whole line
        repeat (8) queue_cmd(twl_pkg::FUNC_WRITE, 1, twl_pkg::CH_TAB);
        // clear drops pending characters
        queue_cmd(twl_pkg::FUNC_WRITE, 3, 8'h78);
        queue_cmd(twl_pkg::FUNC_CLEAR, 3, 8'h00);
        queue_cmd(twl_pkg::FUNC_WRITE, 3, twl_pkg::CH_NL);

        // random part: mostly lines ending in a newline, window 2 favored to reach scroll
        while (queued_count < TOTAL_ITEMS)
        begin
            pick = $urandom_range(99);
            w = ($urandom_range(99) < 70) ? 2 : $urandom_range(3);
            if (pick < 2)
                queue_cmd(twl_pkg::FUNC_CLEAR, w, $urandom_range(255));
            else if (pick < 10)
                repeat ($urandom_range(1, 6))
                    queue_cmd(twl_pkg::FUNC_WRITE, $urandom_range(3), $urandom_range(255));
            else
            begin
                lp  = $urandom_range(99);
                len = (lp < 50) ? 0 : (lp < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                for (i = 0; i < len; i++)
                    queue_cmd(twl_pkg::FUNC_WRITE, w,
                              ($urandom_range(99) < 15) ? twl_pkg::CH_TAB : $urandom_range(255));
                if ($urandom_range(99) < 90)
                    queue_cmd(twl_pkg::FUNC_WRITE, w, twl_pkg::CH_NL);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every command to go out and every result to come back
        while (char_queue.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_cells.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
